// File: hdl/ordered_array_insert_delete_macros.svh
// Assertion macros shared by the ordered array RTL.
`ifndef ORDERED_ARRAY_INSERT_DELETE_MACROS_SVH
`define ORDERED_ARRAY_INSERT_DELETE_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define OAID_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define OAID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/oaid_pkg.sv
// Shared types and codes of the ordered array block.
package oaid_pkg;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_INSERT = 2'd2,
        OP_DELETE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT,
        S_RD_WAIT,
        S_RESULT
    } t_state;

    // One result item
    typedef struct packed {
        logic signed [31:0] read_data;
        logic [8:0]         length;
        t_status            status;
    } t_result;

    // Port strobes from the controller to the entry memory
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_ram_ctl;

endpackage

// File: hdl/oaid_if.sv
// Request and response channel interfaces of the ordered array block.
interface oaid_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic [8:0]        position;
    logic signed [31:0] value;

    modport source (output valid, operation, position, value, input ready);
    modport sink (input valid, operation, position, value, output ready);
endinterface

interface oaid_out_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] read_data;
    logic [8:0]        length;
    logic [1:0]        status;

    modport source (output valid, read_data, length, status, input ready);
    modport sink (input valid, read_data, length, status, output ready);
endinterface

// File: hdl/oaid_ram.sv
// Entry memory: one write port, one read port with registered read data.
module oaid_ram
    import oaid_pkg::*;
#(
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  t_ram_ctl           i_ctl,
    input  logic [AW-1:0]      i_waddr,
    input  logic signed [31:0] i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output logic signed [31:0] o_rdata
);

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, hold data until the next read
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/oaid_ctrl.sv
// Request sequencer: decodes operations and moves entries through the memory.
module oaid_ctrl
    import oaid_pkg::*;
#(
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH),
    localparam int CNTW = $clog2(DEPTH + 1),
    localparam int CMPW = (CNTW > 9) ? CNTW : 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    oaid_in_if.sink            i_req,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output t_result            o_res,
    output t_ram_ctl           o_ram_ctl,
    output logic [AW-1:0]      o_ram_waddr,
    output logic signed [31:0] o_ram_wdata,
    output logic [AW-1:0]      o_ram_raddr,
    input  logic signed [31:0] i_ram_rdata
);

    t_state             r_state, n_state;
    logic [CNTW-1:0]    r_count, n_count;
    logic [1:0]         r_op, n_op;
    logic [CMPW-1:0]    r_pos, n_pos;
    logic signed [31:0] r_val, n_val;
    logic [AW-1:0]      r_src, n_src;
    logic [AW-1:0]      r_dst, n_dst;
    logic [CNTW-1:0]    r_left, n_left;
    logic               r_pend, n_pend;
    logic               r_up, n_up;
    logic signed [31:0] r_res_data, n_res_data;
    t_status            r_status, n_status;

    logic [CMPW-1:0]    s_cnt_ext;
    logic [CMPW-1:0]    s_pos_min;
    logic               s_full;

    assign s_cnt_ext = CMPW'(r_count);
    assign s_pos_min = (r_pos > s_cnt_ext) ? s_cnt_ext : r_pos;
    assign s_full    = (s_cnt_ext == CMPW'(DEPTH));

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    // Request and move registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_pos      <= n_pos;
        r_val      <= n_val;
        r_src      <= n_src;
        r_dst      <= n_dst;
        r_left     <= n_left;
        r_up       <= n_up;
        r_res_data <= n_res_data;
        r_status   <= n_status;
    end

    // Next state and memory strobes
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_op        = r_op;
        n_pos       = r_pos;
        n_val       = r_val;
        n_src       = r_src;
        n_dst       = r_dst;
        n_left      = r_left;
        n_pend      = r_pend;
        n_up        = r_up;
        n_res_data  = r_res_data;
        n_status    = r_status;
        o_ram_ctl   = '0;
        o_ram_waddr = r_dst;
        o_ram_wdata = i_ram_rdata;
        o_ram_raddr = r_src;
        i_req.ready = (r_state == S_IDLE);
        o_res_valid = (r_state == S_RESULT);

        case (r_state)
            S_IDLE: begin
                // Capture the request
                if (i_req.valid) begin
                    n_op    = i_req.operation;
                    n_pos   = CMPW'(i_req.position);
                    n_val   = i_req.value;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_res_data = '0;
                n_status   = ST_DONE;
                n_state    = S_RESULT;
                case (t_op'(r_op))
                    OP_READ: begin
                        if (r_pos < s_cnt_ext) begin
                            o_ram_ctl.rd_en = 1'b1;
                            o_ram_raddr     = r_pos[AW-1:0];
                            n_state         = S_RD_WAIT;
                        end else begin
                            n_status = ST_RANGE;
                        end
                    end
                    OP_WRITE: begin
                        if (r_pos < s_cnt_ext) begin
                            o_ram_ctl.wr_en = 1'b1;
                            o_ram_waddr     = r_pos[AW-1:0];
                            o_ram_wdata     = r_val;
                        end else if (r_pos == s_cnt_ext) begin
                            if (s_full) begin
                                n_status = ST_FULL;
                            end else begin
                                o_ram_ctl.wr_en = 1'b1;
                                o_ram_waddr     = r_pos[AW-1:0];
                                o_ram_wdata     = r_val;
                                n_count         = r_count + CNTW'(1);
                            end
                        end else begin
                            n_status = ST_RANGE;
                        end
                    end
                    OP_INSERT: begin
                        if (s_full) begin
                            n_status = ST_FULL;
                        end else begin
                            // Move entries up, top entry first
                            n_pos   = s_pos_min;
                            n_left  = CNTW'(s_cnt_ext - s_pos_min);
                            n_src   = AW'(r_count - CNTW'(1));
                            n_up    = 1'b1;
                            n_pend  = 1'b0;
                            n_state = S_SHIFT;
                        end
                    end
                    OP_DELETE: begin
                        if (r_pos < s_cnt_ext) begin
                            // Move entries down, lowest entry first
                            n_left  = CNTW'(s_cnt_ext - r_pos - CMPW'(1));
                            n_src   = AW'(r_pos + CMPW'(1));
                            n_up    = 1'b0;
                            n_pend  = 1'b0;
                            n_state = S_SHIFT;
                        end else begin
                            n_status = ST_RANGE;
                        end
                    end
                    default: begin
                        n_status = ST_RANGE;
                    end
                endcase
            end
            S_SHIFT: begin
                // Land the word read last cycle one place over
                if (r_pend) begin
                    o_ram_ctl.wr_en = 1'b1;
                    o_ram_waddr     = r_dst;
                    o_ram_wdata     = i_ram_rdata;
                end
                if (r_left != '0) begin
                    o_ram_ctl.rd_en = 1'b1;
                    o_ram_raddr     = r_src;
                    n_pend          = 1'b1;
                    n_dst           = r_up ? (r_src + AW'(1)) : (r_src - AW'(1));
                    n_src           = r_up ? (r_src - AW'(1)) : (r_src + AW'(1));
                    n_left          = r_left - CNTW'(1);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        // Moves drained: place the new entry or shrink
                        if (r_up) begin
                            o_ram_ctl.wr_en = 1'b1;
                            o_ram_waddr     = r_pos[AW-1:0];
                            o_ram_wdata     = r_val;
                            n_count         = r_count + CNTW'(1);
                        end else begin
                            n_count = r_count - CNTW'(1);
                        end
                        n_state = S_RESULT;
                    end
                end
            end
            S_RD_WAIT: begin
                n_res_data = i_ram_rdata;
                n_state    = S_RESULT;
            end
            S_RESULT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res.read_data = r_res_data;
    assign o_res.length    = s_cnt_ext[8:0];
    assign o_res.status    = r_status;

endmodule

// File: hdl/ordered_array_insert_delete.sv
// Ordered array block: top level with output register and checks.
//
// Keeps a packed array of up to DEPTH signed 32-bit entries in one
// single-port-write, single-port-read memory, plus a live length. One
// request is handled at a time. An insert moves each entry at or above
// the position, clamped to the length, up by one place; a delete moves
// each entry above the position down by one place. Moves run one entry
// per cycle through the memory's one read and one write port. An insert
// that appends, or a delete of the last entry, moves nothing. A new
// request is taken while the last result still waits in the output
// register. No clearing pass runs after reset.
module ordered_array_insert_delete
    import oaid_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    oaid_in_if.sink   i_req,
    oaid_out_if.source o_rsp
);

`include "ordered_array_insert_delete_macros.svh"

    localparam int AW       = $clog2(DEPTH);
    localparam int FULL_LEN = DEPTH % 512;

    t_ram_ctl           s_ram_ctl;
    logic [AW-1:0]      s_ram_waddr;
    logic [AW-1:0]      s_ram_raddr;
    logic signed [31:0] s_ram_wdata;
    logic signed [31:0] s_ram_rdata;
    logic               s_res_valid;
    logic               s_res_ready;
    t_result            s_res;

    logic               r_out_valid;
    t_result            r_out;

    oaid_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_res_valid (s_res_valid),
        .i_res_ready (s_res_ready),
        .o_res       (s_res),
        .o_ram_ctl   (s_ram_ctl),
        .o_ram_waddr (s_ram_waddr),
        .o_ram_wdata (s_ram_wdata),
        .o_ram_raddr (s_ram_raddr),
        .i_ram_rdata (s_ram_rdata)
    );

    oaid_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_ctl   (s_ram_ctl),
        .i_waddr (s_ram_waddr),
        .i_wdata (s_ram_wdata),
        .i_raddr (s_ram_raddr),
        .o_rdata (s_ram_rdata)
    );

    // Take a result when the output register is empty or draining
    assign s_res_ready = !r_out_valid || o_rsp.ready;

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_res_ready) begin
            r_out_valid <= s_res_valid;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (s_res_valid && s_res_ready) begin
            r_out <= s_res;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_data = r_out.read_data;
    assign o_rsp.length    = r_out.length;
    assign o_rsp.status    = r_out.status;

    // A refusal for a full array reports the full length
    `OAID_ASSERT_SAME(a_full_len, i_clk, i_rst_n, s_res_valid && (s_res.status == ST_FULL), s_res.length == 9'(FULL_LEN), "full refusal with wrong length")

    // Only a completed read carries data
    `OAID_ASSERT_SAME(a_zero_data, i_clk, i_rst_n, s_res_valid && (s_res.status != ST_DONE), s_res.read_data == 32'sd0, "refusal with nonzero read data")

    // One request at a time: no back-to-back transfers
    `OAID_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready, "request taken while busy")

endmodule

// File: verif/ordered_array_insert_delete_tb.sv
// Self-checking testbench for the ordered array block: random traffic against a shadow array.
module ordered_array_insert_delete_tb;
    import oaid_pkg::*;

    localparam int DEPTH         = 256;
    localparam int RANDOM_ITEMS  = 1130;
    localparam int TAIL_ITEMS    = 100;
    localparam int HOLD_AT       = 200;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;

    typedef enum {
        FILL_UP,
        MIXED,
        DRAIN_DOWN
    } t_sweep;

    typedef struct {
        t_op                op;
        logic [8:0]         pos;
        logic signed [31:0] val;
        bit                 wait_idle;
    } t_req_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    oaid_in_if  req_if ();
    oaid_out_if rsp_if ();

    ordered_array_insert_delete #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    // Shadow copy of the array contents and its live length
    logic signed [31:0] shadow_words [DEPTH];
    int                 shadow_len = 0;

    t_req_item queued_requests [$];
    t_result   pending_responses [$];

    int n_taken = 0;
    int n_done  = 0;
    int n_fail  = 0;
    int plan_len = 0;
    int total_items;

    int send_gap;
    bit calm_tail;
    int stall_left;
    int hold_left;
    bit hold_done;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Apply one request to the shadow array and return the result it yields
    function automatic t_result compute_response(t_op op, logic [8:0] pos,
                                                 logic signed [31:0] val);
        t_result rsp;
        int      p;
        int      k;
        rsp.read_data = '0;
        rsp.status    = ST_DONE;
        p = pos;
        case (op)
            OP_READ: begin
                if (p < shadow_len) rsp.read_data = shadow_words[p];
                else rsp.status = ST_RANGE;
            end
            OP_WRITE: begin
                if (p < shadow_len) begin
                    shadow_words[p] = val;
                end else if (p == shadow_len) begin
                    if (shadow_len >= DEPTH) begin
                        rsp.status = ST_FULL;
                    end else begin
                        shadow_words[shadow_len] = val;
                        shadow_len++;
                    end
                end else begin
                    rsp.status = ST_RANGE;
                end
            end
            OP_INSERT: begin
                if (shadow_len >= DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    // Clamp a position past the end to an append
                    if (p > shadow_len) p = shadow_len;
                    for (k = shadow_len; k > p; k--) shadow_words[k] = shadow_words[k - 1];
                    shadow_words[p] = val;
                    shadow_len++;
                end
            end
            default: begin
                if (p < shadow_len) begin
                    for (k = p; k + 1 < shadow_len; k++) shadow_words[k] = shadow_words[k + 1];
                    shadow_len--;
                end else begin
                    rsp.status = ST_RANGE;
                end
            end
        endcase
        rsp.length = shadow_len[8:0];
        return rsp;
    endfunction

    // Queue one request and track the length it will leave behind
    task automatic add_item(t_op op, int pos, logic signed [31:0] val, bit wait_idle = 1'b0);
        t_req_item item;
        item.op        = op;
        item.pos       = pos[8:0];
        item.val       = val;
        item.wait_idle = wait_idle;
        queued_requests.push_back(item);
        case (op)
            OP_WRITE:  if (pos == plan_len && plan_len < DEPTH) plan_len++;
            OP_INSERT: if (plan_len < DEPTH) plan_len++;
            OP_DELETE: if (pos < plan_len) plan_len--;
            default: ;
        endcase
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Request driver: hold each item until its transfer, insert random gaps
    always @(posedge i_clk) begin
        t_req_item item;
        bit        settled;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            send_gap     <= 0;
            calm_tail    <= 1'b0;
        end else begin
            settled = (n_taken + ((req_if.valid && req_if.ready) ? 1 : 0)) == n_done;
            if (!req_if.valid || req_if.ready) begin
                if (send_gap != 0) begin
                    req_if.valid <= 1'b0;
                    send_gap     <= send_gap - 1;
                end else if (queued_requests.size() != 0 &&
                             !(queued_requests[0].wait_idle && !settled)) begin
                    item = queued_requests.pop_front();
                    req_if.valid     <= 1'b1;
                    req_if.operation <= item.op;
                    req_if.position  <= item.pos;
                    req_if.value     <= item.val;
                    if (!calm_tail && $urandom_range(0, 4) == 0)
                        send_gap <= $urandom_range(1, 4);
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
            calm_tail <= (queued_requests.size() <= TAIL_ITEMS);
        end
    end

    // Response acceptor: short random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_left   <= 0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end else if (hold_left != 0) begin
            rsp_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (!hold_done && n_done >= HOLD_AT) begin
            rsp_if.ready <= 1'b0;
            hold_done    <= 1'b1;
            hold_left    <= HOLD_CYCLES - 1;
        end else if (stall_left != 0) begin
            rsp_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 3);
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // Predict on each request transfer, check each response transfer
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                pending_responses.push_back(compute_response(t_op'(req_if.operation),
                                                             req_if.position, req_if.value));
                n_taken <= n_taken + 1;
            end
            if (rsp_if.valid && rsp_if.ready) begin
                n_done <= n_done + 1;
                if (pending_responses.size() == 0) begin
                    $error("response with no request outstanding: read_data %0d length %0d status %0d",
                           rsp_if.read_data, rsp_if.length, rsp_if.status);
                    n_fail++;
                end else begin
                    want = pending_responses.pop_front();
                    if (rsp_if.read_data !== want.read_data) begin
                        $error("read_data: expected %0d, got %0d", want.read_data, rsp_if.read_data);
                        n_fail++;
                    end
                    if (rsp_if.length !== want.length) begin
                        $error("length: expected %0d, got %0d", want.length, rsp_if.length);
                        n_fail++;
                    end
                    if (rsp_if.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                        n_fail++;
                    end
                end
            end
        end
    end

    // Stimulus: directed corner cases, then fill/churn/drain sweeps
    initial begin
        t_sweep sweep;
        int     churn_left;
        int     roll;
        int     pos;
        int     t_ins;
        int     t_app;
        int     t_read;
        int     t_ovw;
        int     t_del;
        bit     hold_first;
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.operation = OP_READ;
        req_if.position  = '0;
        req_if.value     = '0;
        rsp_if.ready     = 1'b0;

        // Refusals on the empty array, no underflow on delete
        add_item(OP_READ, 0, pick_value());
        add_item(OP_DELETE, 0, pick_value());
        add_item(OP_WRITE, 1, 32'sh1234_5678);
        // Append, insert at the front, insert past the end, overwrite
        add_item(OP_WRITE, 0, 32'sh7FFF_FFFF);
        add_item(OP_INSERT, 0, 32'sh8000_0000);
        add_item(OP_INSERT, DEPTH, -32'sd1);
        add_item(OP_WRITE, 1, 32'sh0000_0000);
        for (int i = 0; i < 3; i++) add_item(OP_READ, i, pick_value());
        // Reads and writes at and beyond the end
        add_item(OP_READ, 3, pick_value());
        add_item(OP_READ, DEPTH, pick_value());
        add_item(OP_WRITE, 5, 32'sh0F0F_0F0F);
        add_item(OP_WRITE, 3, 32'sh5555_5555);
        add_item(OP_INSERT, 2, 32'shAAAA_AAAA);
        // Delete in the middle, at the end, and one past the end
        add_item(OP_DELETE, 1, pick_value());
        add_item(OP_DELETE, 4, pick_value());
        add_item(OP_DELETE, 3, pick_value());
        for (int i = 0; i < 3; i++) add_item(OP_READ, i, pick_value());
        for (int i = 0; i < 3; i++) add_item(OP_DELETE, 0, pick_value());
        add_item(OP_DELETE, 0, pick_value());
        add_item(OP_READ, 0, pick_value());

        sweep      = FILL_UP;
        churn_left = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            hold_first = (i == 0) || (i == RANDOM_ITEMS / 2);
            // Probe the full and empty boundaries at each turn of the sweep
            if (sweep == FILL_UP && plan_len == DEPTH) begin
                add_item(OP_WRITE, DEPTH, pick_value());
                add_item(OP_INSERT, $urandom_range(0, DEPTH), pick_value());
                add_item(OP_READ, DEPTH - 1, pick_value());
                sweep      = MIXED;
                churn_left = 100;
            end else if (sweep == MIXED && churn_left == 0) begin
                sweep = DRAIN_DOWN;
            end else if (sweep == DRAIN_DOWN && plan_len == 0) begin
                add_item(OP_DELETE, $urandom_range(0, DEPTH), pick_value());
                add_item(OP_READ, 0, pick_value());
                add_item(OP_WRITE, $urandom_range(1, DEPTH), pick_value());
                sweep = FILL_UP;
            end

            case (sweep)
                FILL_UP: begin
                    t_ins = 50; t_app = 75; t_read = 85; t_ovw = 90; t_del = 95;
                end
                MIXED: begin
                    t_ins = 30; t_app = 35; t_read = 55; t_ovw = 65; t_del = 95;
                end
                default: begin
                    t_ins = 10; t_app = 12; t_read = 25; t_ovw = 30; t_del = 90;
                end
            endcase

            roll = $urandom_range(0, 99);
            if (roll < t_ins) begin
                pos = ($urandom_range(0, 7) == 0) ? $urandom_range(plan_len, DEPTH)
                                                  : $urandom_range(0, plan_len);
                add_item(OP_INSERT, pos, pick_value(), hold_first);
            end else if (roll < t_app || plan_len == 0) begin
                add_item(OP_WRITE, plan_len, pick_value(), hold_first);
            end else if (roll < t_read) begin
                add_item(OP_READ, $urandom_range(0, plan_len - 1), pick_value(), hold_first);
            end else if (roll < t_ovw) begin
                add_item(OP_WRITE, $urandom_range(0, plan_len - 1), pick_value(), hold_first);
            end else if (roll < t_del) begin
                add_item(OP_DELETE, $urandom_range(0, plan_len - 1), pick_value(), hold_first);
            end else begin
                // Out-of-range noise
                case ($urandom_range(0, 2))
                    0: add_item(OP_READ, $urandom_range(plan_len, DEPTH), pick_value(),
                                hold_first);
                    1: add_item(OP_DELETE, $urandom_range(plan_len, DEPTH), pick_value(),
                                hold_first);
                    default: begin
                        pos = (plan_len < DEPTH) ? $urandom_range(plan_len + 1, DEPTH) : DEPTH;
                        add_item(OP_WRITE, pos, pick_value(), hold_first);
                    end
                endcase
            end
            if (sweep == MIXED) churn_left--;
        end
        total_items = queued_requests.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to transfer and every response to return
        do @(posedge i_clk); while (n_taken != total_items || n_done != n_taken);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (pending_responses.size() != 0) begin
            $error("%0d responses never arrived", pending_responses.size());
            n_fail++;
        end
        if (n_fail == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
